>>> hdl/ecal_pkg.sv
package ecal_pkg;

  localparam int EPOCH_W = 32;

  // Day split: t = 128 * q1 + r1, days = floor(q1 / 675).
  // q1 is biased by a multiple of 675 so the divide is unsigned.
  localparam int           U_W       = 26;
  localparam logic [25:0]  DAY_BIAS  = 26'd16777800;      // 675 * 24856
  localparam logic [26:0]  DAY_RECIP = 27'd101806633;     // ceil(2^36 / 675)
  localparam int           DAY_SH    = 36;
  localparam logic [25:0]  DAY_ODD   = 26'd675;

  // Day index (days since epoch + 24856) to days since 1900-03-01.
  localparam logic [15:0]  MARCH1900_OFS = 16'd652;
  localparam logic [16:0]  QUAD_RECIP    = 17'd91868;     // ceil(2^27 / 1461)
  localparam int           QUAD_SH       = 27;
  localparam logic [15:0]  QUAD_DAYS     = 16'd1461;
  // Weekday offset: (days + 4) mod 7 == (day index + 5) mod 7.
  localparam logic [15:0]  WD_OFS        = 16'd5;

  // Time of day.
  localparam logic [13:0]  HOUR_RECIP = 14'd9321;         // ceil(2^21 / 225)
  localparam int           HOUR_SH    = 21;
  localparam logic [16:0]  SEC_HOUR   = 17'd3600;
  localparam logic [10:0]  MIN_RECIP  = 11'd1093;         // ceil(2^14 / 15)
  localparam int           MIN_SH     = 14;
  localparam logic [11:0]  SEC_MIN    = 12'd60;

  // First day of each month in a year that starts on March 1.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };
  localparam logic [3:0] MP_JAN    = 4'd10;
  localparam logic [8:0] JAN1_DOY  = 9'd306;
  localparam logic [8:0] MAR1_YDAY = 9'd59;

  typedef struct packed {
    logic [15:0] day_idx;
    logic [16:0] sod;
  } ecal_split_t;

  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] year_day;
  } ecal_date_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } ecal_time_t;

  // x mod 7 by folding octal digits (8 == 1 mod 7).
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

>>> hdl/ecal_day_split.sv
module ecal_day_split (
  input  logic                      clk,
  input  logic [31:0]               epoch_seconds,
  output ecal_pkg::ecal_split_t     split
);

  // stage 1: coarse shift and bias
  logic [25:0] u_nxt, u_r;
  logic [6:0]  r1_r;
  // stage 2: reciprocal quotient
  logic [52:0] prod;
  logic [15:0] q_nxt, q_r;
  logic [25:0] u2_r;
  logic [6:0]  r1b_r;
  // stage 3: remainder
  logic [25:0] back, r2;
  ecal_pkg::ecal_split_t split_nxt, split_r;

  assign u_nxt = {epoch_seconds[31], epoch_seconds[31:7]} + ecal_pkg::DAY_BIAS;

  assign prod  = 53'(u_r) * 53'(ecal_pkg::DAY_RECIP);
  assign q_nxt = prod[ecal_pkg::DAY_SH+15:ecal_pkg::DAY_SH];

  assign back = 26'(q_r) * ecal_pkg::DAY_ODD;
  assign r2   = u2_r - back;
  always_comb begin
    split_nxt.day_idx = q_r;
    split_nxt.sod     = {r2[9:0], r1b_r};
  end

  always_ff @(posedge clk) begin
    u_r     <= u_nxt;
    r1_r    <= epoch_seconds[6:0];
    q_r     <= q_nxt;
    u2_r    <= u_r;
    r1b_r   <= r1_r;
    split_r <= split_nxt;
  end

  assign split = split_r;

endmodule

>>> hdl/ecal_date.sv
module ecal_date (
  input  logic                   clk,
  input  logic [15:0]            day_idx,
  output ecal_pkg::ecal_date_t   date
);

  // stage 4: four-year block
  logic [15:0] c_nxt, c_r;
  logic [32:0] qprod;
  logic [5:0]  quad_nxt, quad_r;
  logic [2:0]  wd_nxt, wd_r;
  // stage 5: year within block
  logic [15:0] doq;
  logic [1:0]  yiq;
  logic [10:0] doy_w;
  logic [8:0]  doy_nxt, doy_r;
  logic [7:0]  ys_nxt, ys_r;
  logic        leap_nxt, leap_r;
  logic [2:0]  wd5_r;
  // stage 6: month search
  logic [3:0]  mp_nxt, mp_r;
  logic [8:0]  doy6_r;
  logic [7:0]  ys6_r;
  logic        leap6_r;
  logic [2:0]  wd6_r;
  // stage 7: output
  ecal_pkg::ecal_date_t date_nxt, date_r;

  assign c_nxt    = day_idx + ecal_pkg::MARCH1900_OFS;
  assign qprod    = 33'(c_nxt) * 33'(ecal_pkg::QUAD_RECIP);
  assign quad_nxt = qprod[ecal_pkg::QUAD_SH+5:ecal_pkg::QUAD_SH];
  assign wd_nxt   = ecal_pkg::mod7(day_idx + ecal_pkg::WD_OFS);

  always_comb begin
    doq = c_r - 16'(quad_r) * ecal_pkg::QUAD_DAYS;
    if (doq >= 16'd1095)     yiq = 2'd3;
    else if (doq >= 16'd730) yiq = 2'd2;
    else if (doq >= 16'd365) yiq = 2'd1;
    else                     yiq = 2'd0;
    doy_w    = doq[10:0] - 11'(yiq) * 11'd365;
    doy_nxt  = doy_w[8:0];
    ys_nxt   = {quad_r, yiq};
    // 1900 is the only year at the start of a block that is not leap
    leap_nxt = (yiq == 2'd0) && (quad_r != 6'd0);
  end

  always_comb begin
    mp_nxt = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_r >= ecal_pkg::MONTH_START[i]) mp_nxt = 4'(i);
    end
  end

  always_comb begin
    date_nxt.weekday      = wd6_r;
    date_nxt.day_of_month = 5'(doy6_r - ecal_pkg::MONTH_START[mp_r] + 9'd1);
    if (mp_r < ecal_pkg::MP_JAN) begin
      date_nxt.month_index      = mp_r + 4'd2;
      date_nxt.years_since_1900 = ys6_r;
      date_nxt.year_day         = doy6_r + ecal_pkg::MAR1_YDAY + 9'(leap6_r);
    end else begin
      date_nxt.month_index      = mp_r - ecal_pkg::MP_JAN;
      date_nxt.years_since_1900 = ys6_r + 8'd1;
      date_nxt.year_day         = doy6_r - ecal_pkg::JAN1_DOY;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    quad_r  <= quad_nxt;
    wd_r    <= wd_nxt;
    doy_r   <= doy_nxt;
    ys_r    <= ys_nxt;
    leap_r  <= leap_nxt;
    wd5_r   <= wd_r;
    mp_r    <= mp_nxt;
    doy6_r  <= doy_r;
    ys6_r   <= ys_r;
    leap6_r <= leap_r;
    wd6_r   <= wd5_r;
    date_r  <= date_nxt;
  end

  assign date = date_r;

endmodule

>>> hdl/ecal_clock.sv
module ecal_clock (
  input  logic                   clk,
  input  logic [16:0]            sod,
  output ecal_pkg::ecal_time_t   tod
);

  // stage 4: hour
  logic [26:0] hprod;
  logic [4:0]  hour_nxt, hour_r;
  logic [16:0] sod_r;
  // stage 5: seconds within the hour
  logic [16:0] rem_w;
  logic [11:0] rem_r;
  logic [4:0]  hour5_r;
  // stage 6: minute
  logic [20:0] mprod;
  logic [5:0]  min_nxt, min_r;
  logic [11:0] rem6_r;
  logic [4:0]  hour6_r;
  // stage 7: output
  logic [11:0] sec_w;
  ecal_pkg::ecal_time_t tod_nxt, tod_r;

  assign hprod    = 27'(sod[16:4]) * 27'(ecal_pkg::HOUR_RECIP);
  assign hour_nxt = hprod[ecal_pkg::HOUR_SH+4:ecal_pkg::HOUR_SH];

  assign rem_w = sod_r - 17'(hour_r) * ecal_pkg::SEC_HOUR;

  assign mprod   = 21'(rem_r[11:2]) * 21'(ecal_pkg::MIN_RECIP);
  assign min_nxt = mprod[ecal_pkg::MIN_SH+5:ecal_pkg::MIN_SH];

  assign sec_w = rem6_r - 12'(min_r) * ecal_pkg::SEC_MIN;
  always_comb begin
    tod_nxt.second = sec_w[5:0];
    tod_nxt.minute = min_r;
    tod_nxt.hour   = hour6_r;
  end

  always_ff @(posedge clk) begin
    hour_r  <= hour_nxt;
    sod_r   <= sod;
    rem_r   <= rem_w[11:0];
    hour5_r <= hour_r;
    min_r   <= min_nxt;
    rem6_r  <= rem_r;
    hour6_r <= hour5_r;
    tod_r   <= tod_nxt;
  end

  assign tod = tod_r;

endmodule

>>> hdl/epoch_seconds_to_calendar.sv
// Channel   Ports                         Direction  Transaction
// input     start, busy, in_epoch_seconds in         start && !busy at a rising edge
// result    out_valid, out_*              out        out_valid for one cycle, always taken
//
// One transaction per cycle, back to back; busy is never raised.
// 3 stages split seconds into day index and second of
// day, then 4 stages in parallel build the date and the time of day.
// Each stage holds about one constant multiply with a subtract or compare.
// Reset (rst_n, synchronous) clears only the valid pipeline.
// The receiver cannot stall; results leave in the order they were accepted.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_index,
  output logic [7:0]  out_years_since_1900,
  output logic [2:0]  out_weekday,
  output logic [8:0]  out_year_day
);

  localparam int LAT = 7;

  logic                   accept;
  logic [LAT-1:0]         vld_nxt, vld_r;
  ecal_pkg::ecal_split_t  split;
  ecal_pkg::ecal_date_t   date;
  ecal_pkg::ecal_time_t   tod;

  // Fully pipelined: a new transaction can enter every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bit follows its data through the seven register stages.
  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stages 1-3: floor division by 86400.
  ecal_day_split u_split (
    .clk           (clk),
    .epoch_seconds (in_epoch_seconds),
    .split         (split)
  );

  // Stages 4-7: four-year block, year, month, day, weekday.
  ecal_date u_date (
    .clk     (clk),
    .day_idx (split.day_idx),
    .date    (date)
  );

  // Stages 4-7: hour, minute, second.
  ecal_clock u_clock (
    .clk (clk),
    .sod (split.sod),
    .tod (tod)
  );

  assign out_valid            = vld_r[LAT-1];
  assign out_second           = tod.second;
  assign out_minute           = tod.minute;
  assign out_hour             = tod.hour;
  assign out_day_of_month     = date.day_of_month;
  assign out_month_index      = date.month_index;
  assign out_years_since_1900 = date.years_since_1900;
  assign out_weekday          = date.weekday;
  assign out_year_day         = date.year_day;

endmodule

>>> hdl/ecal_checker.sv
module ecal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [5:0]  out_second,
  input logic [5:0]  out_minute,
  input logic [4:0]  out_hour,
  input logic [4:0]  out_day_of_month,
  input logic [3:0]  out_month_index,
  input logic [7:0]  out_years_since_1900,
  input logic [2:0]  out_weekday,
  input logic [8:0]  out_year_day
);

  logic [2:0] up_cnt_nxt, up_cnt_r;

  // cycles since reset release, saturating
  assign up_cnt_nxt = (up_cnt_r == 3'd7) ? up_cnt_r : up_cnt_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cnt_r <= '0;
    end else begin
      up_cnt_r <= up_cnt_nxt;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (up_cnt_r == 3'd7) |-> (out_valid == $past(start && !busy, 7)))
    else $error("result strobe not 7 cycles after transaction");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'd60 && out_minute < 6'd60 && out_hour < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_of_month != 5'd0 && out_month_index < 4'd12 &&
                   out_weekday < 3'd7 && out_year_day <= 9'd365 &&
                   out_years_since_1900 != 8'd0 && out_years_since_1900 <= 8'd138))
    else $error("date field out of range");

  a_january: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_month_index == 4'd0) |->
      (out_year_day == 9'(out_day_of_month) - 9'd1))
    else $error("January day of year mismatch");

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_second           (out_second),
  .out_minute           (out_minute),
  .out_hour             (out_hour),
  .out_day_of_month     (out_day_of_month),
  .out_month_index      (out_month_index),
  .out_years_since_1900 (out_years_since_1900),
  .out_weekday          (out_weekday),
  .out_year_day         (out_year_day)
);
